FILE: src/fifo_from_two_stacks_defines.svh
// Assertion macros for the two-stack queue.
// Included by files that carry concurrent assertions; expects clk and arst_n in scope.
`ifndef FIFO_FROM_TWO_STACKS_DEFINES_SVH
`define FIFO_FROM_TWO_STACKS_DEFINES_SVH
`ifndef ASSERT_OFF
// Check a property on every rising clock edge outside reset
`define FTS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Check that a condition never holds outside reset
`define FTS_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define FTS_ASSERT(lbl, prop, msg)
`define FTS_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

FILE: src/fts_pkg.sv
// Shared types and codes for the two-stack queue.
// No dependencies; used by the top level and its port list.
`default_nettype none

package fts_pkg;

	// Operation codes
	localparam logic FUNC_ENQ = 1'b0;
	localparam logic FUNC_DEQ = 1'b1;

	// Result status codes
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	// Capacity register
	localparam int         CAP_W     = 8;
	localparam logic [7:0] CAP_RESET = 8'd128;

	typedef struct packed {
		logic               func;
		logic signed [31:0] value_in;
	} req_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] value_out;
	} rsp_item_t;

endpackage

`default_nettype wire

FILE: src/fts_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
`default_nettype none

module fts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port, registered read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: src/fifo_from_two_stacks.sv
// Two-stack queue: an item is an enqueue or a dequeue and yields exactly one result
// item. Both stacks live in RAMs with registered read data. An enqueue needs no RAM
// read; a dequeue from a non-empty output stack does one RAM read. A dequeue that
// finds the output stack empty reads the n entries of the input stack, one RAM read
// per cycle, pushes the top n-1 onto the output stack and hands the bottom entry
// straight out; each entry moves only once. One item is worked on at a time; a
// finished result waits in the output register, so the next item can be taken while
// it is unclaimed. The capacity register (reset 128) limits the input stack only.
// Depends on fts_pkg, fts_ram and fifo_from_two_stacks_defines.svh.
`default_nettype none
`include "fifo_from_two_stacks_defines.svh"

module fifo_from_two_stacks #(
	parameter int STACK_DEPTH = 128,
	parameter int DATA_WIDTH  = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire fts_pkg::req_item_t req,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output fts_pkg::rsp_item_t     rsp,
	input  wire logic              cfg_wr_en,
	input  wire logic [7:0]        cfg_wr_data
);

	import fts_pkg::*;

	localparam int AW    = $clog2(STACK_DEPTH);
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_XFER = 4'b0010,
		S_POP  = 4'b0100,
		S_HOLD = 4'b1000
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] in_cnt_q, in_cnt_d, out_cnt_q, out_cnt_d;
	logic [CNT_W-1:0] in_cnt_dec, out_cnt_dec;
	logic [7:0]       cap_q;
	logic             rd_pend_s1, rd_pend_d, last_s1, last_d;
	logic             rsp_valid_q;
	rsp_item_t        rsp_q, res_q, done_item, rsp_d;
	logic             req_fire, slot_free, in_full, done, load_rsp;

	logic                  in_we, in_re, out_we, out_re;
	logic [DATA_WIDTH-1:0] in_wdata, in_rdata, out_rdata;

	// Sign-extend a stored entry to the 32-bit result field
	function automatic logic [31:0] widen(input logic [DATA_WIDTH-1:0] d);
		logic [63:0] w;
		w = 64'(signed'(d));
		return w[31:0];
	endfunction

	assign req_fire    = req_valid && req_ready;
	assign req_ready   = (state_q == S_IDLE);
	assign slot_free   = !rsp_valid_q || rsp_ready;
	assign in_cnt_dec  = in_cnt_q - CNT_ONE;
	assign out_cnt_dec = out_cnt_q - CNT_ONE;
	assign in_wdata    = DATA_WIDTH'($unsigned(req.value_in));
	assign in_full     = (CMP_W'(in_cnt_q) >= CMP_W'(cap_q)) || (in_cnt_q >= CNT_FULL);

	// Stack memories
	fts_ram #(.WIDTH(DATA_WIDTH), .DEPTH(STACK_DEPTH)) u_in_ram (
		.clk     (clk),
		.wr_en   (in_we),
		.wr_addr (in_cnt_q[AW-1:0]),
		.wr_data (in_wdata),
		.rd_en   (in_re),
		.rd_addr (in_cnt_dec[AW-1:0]),
		.rd_data (in_rdata)
	);

	fts_ram #(.WIDTH(DATA_WIDTH), .DEPTH(STACK_DEPTH)) u_out_ram (
		.clk     (clk),
		.wr_en   (out_we),
		.wr_addr (out_cnt_q[AW-1:0]),
		.wr_data (in_rdata),
		.rd_en   (out_re),
		.rd_addr (out_cnt_dec[AW-1:0]),
		.rd_data (out_rdata)
	);

	// Sequence the operation: push, pop, or transfer that hands out the bottom entry
	always_comb begin
		state_d   = state_q;
		in_cnt_d  = in_cnt_q;
		out_cnt_d = out_cnt_q;
		rd_pend_d = 1'b0;
		last_d    = 1'b0;
		in_we     = 1'b0;
		in_re     = 1'b0;
		out_we    = 1'b0;
		out_re    = 1'b0;
		done      = 1'b0;
		done_item = '{status: STATUS_OK, value_out: '0};
		unique case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					priority if (req.func == FUNC_ENQ) begin
						done = 1'b1;
						if (in_full) begin
							done_item.status = STATUS_FULL;
						end else begin
							in_we    = 1'b1;
							in_cnt_d = in_cnt_q + CNT_ONE;
						end
					end else if (out_cnt_q != '0) begin
						out_re    = 1'b1;
						out_cnt_d = out_cnt_dec;
						state_d   = S_POP;
					end else if (in_cnt_q != '0) begin
						in_re     = 1'b1;
						in_cnt_d  = in_cnt_dec;
						rd_pend_d = 1'b1;
						last_d    = (in_cnt_q == CNT_ONE);
						state_d   = S_XFER;
					end else begin
						done             = 1'b1;
						done_item.status = STATUS_EMPTY;
					end
				end
			end
			S_XFER: begin
				// Issue the next read while entries remain
				if (in_cnt_q != '0) begin
					in_re     = 1'b1;
					in_cnt_d  = in_cnt_dec;
					rd_pend_d = 1'b1;
					last_d    = (in_cnt_q == CNT_ONE);
				end
				// Push the read entry, or hand the bottom entry straight out
				if (rd_pend_s1) begin
					if (last_s1) begin
						done                = 1'b1;
						done_item.value_out = widen(in_rdata);
					end else begin
						out_we    = 1'b1;
						out_cnt_d = out_cnt_q + CNT_ONE;
					end
				end
			end
			S_POP: begin
				done                = 1'b1;
				done_item.value_out = widen(out_rdata);
			end
			S_HOLD: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (done) begin
			state_d = slot_free ? S_IDLE : S_HOLD;
		end
	end

	assign load_rsp = (done || state_q == S_HOLD) && slot_free;
	assign rsp_d    = (state_q == S_HOLD) ? res_q : done_item;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			in_cnt_q    <= '0;
			out_cnt_q   <= '0;
			cap_q       <= CAP_RESET;
			rd_pend_s1  <= 1'b0;
			last_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			in_cnt_q   <= in_cnt_d;
			out_cnt_q  <= out_cnt_d;
			rd_pend_s1 <= rd_pend_d;
			last_s1    <= last_d;
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Result payload: output register and hold slot
	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_q <= rsp_d;
		end
		if (done && !slot_free) begin
			res_q <= done_item;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Checks
	`FTS_ASSERT(a_cnt_range, (in_cnt_q <= CNT_FULL) && (out_cnt_q <= CNT_FULL), "stack count beyond depth")
	`FTS_ASSERT_NEVER(a_xfer_room, out_we && (out_cnt_q >= CNT_FULL), "transfer overruns output stack")
	`FTS_ASSERT(a_xfer_drain, (state_q == S_XFER && rd_pend_s1 && last_s1) |-> (in_cnt_q == '0), "transfer ended with input stack not empty")
	`FTS_ASSERT(a_enq_push, (req_fire && req.func == FUNC_ENQ && !in_full) |=> (in_cnt_q == $past(in_cnt_q) + CNT_ONE), "accepted enqueue did not push")
	`FTS_ASSERT_NEVER(a_hold_busy, req_ready && (state_q == S_HOLD), "item taken while a result is held")

endmodule

`default_nettype wire
